FILE: design/asc_lru_pkg.sv
// Shared types and constants for the associative sector cache.
`default_nettype none
package asc_lru_pkg;

  localparam int ENTRIES    = 64;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int TAG_W      = 32;
  localparam int AGE_W      = 32;
  localparam int SLOT_W     = 6;
  localparam int WORD_W     = 64;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_DISPATCH,
    S_OLD_RD,
    S_OLD_CMP,
    S_PAY_RD,
    S_PAY_WAIT,
    S_MOVE_RD,
    S_MOVE_WAIT,
    S_WRITE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: design/assoc_sector_cache_lru.sv
// Fully associative sector cache with least-recently-put replacement.
//
// Requests enter on the s_axis channel: s_axis_tuser carries the operation
// (get, put, remove, clear), s_axis_tdata the block number and payload word.
// Each request yields exactly one result on the m_axis channel: m_axis_tuser
// is the hit flag, m_axis_tdata the payload read by a get hit and the slot.
//
// One request is handled at a time by a sequencer around a single-port
// read of the tag, age and payload memories (read data registered).
// The tag search walks the filled slots from the newest down, a read state
// and a compare state per slot, and stops at the first match. A put miss on
// a full cache adds a sweep over all ages to pick the slot to replace.
//
// s_axis_tready is high only while the block is idle. The result stays on
// m_axis with all fields held until m_axis_tready takes it; no new request
// is accepted before then. Synchronous reset empties the cache and clears
// the put counter; the memories themselves are not cleared, since only
// filled slots are ever read.
`default_nettype none
module assoc_sector_cache_lru
  import asc_lru_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,   // block_id[31:0], data_in[95:32]
  input  wire logic [1:0]   s_axis_tuser,   // operation[1:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,   // data_out[63:0], slot[69:64], zero pad
  output logic [0:0]        m_axis_tuser    // hit[0]
);

  state_t state, state_next;

  // Request registers.
  op_t                   op;
  logic [TAG_W-1:0]      op_tag;
  logic [DATA_WIDTH-1:0] op_data;

  // Cache control state.
  logic [CNT_W-1:0] fill;
  logic [AGE_W-1:0] put_counter;

  // Sequencer working registers.
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] idx;
  logic             found;
  logic [AGE_W-1:0] best_age;

  // Result registers.
  logic                  res_hit;
  logic [DATA_WIDTH-1:0] res_data;
  logic [SLOT_W-1:0]     res_slot;

  // Memories and their registered read data.
  logic [TAG_W-1:0]      tag_mem [ENTRIES];
  logic [AGE_W-1:0]      age_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] pay_mem [ENTRIES];
  logic [TAG_W-1:0]      tag_q;
  logic [AGE_W-1:0]      age_q;
  logic [DATA_WIDTH-1:0] pay_q;

  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  tag_we, age_we, pay_we;
  logic [TAG_W-1:0]      tag_wdata;
  logic [AGE_W-1:0]      age_wdata;
  logic [DATA_WIDTH-1:0] pay_wdata;

  logic             accept;
  logic [IDX_W-1:0] last_idx;
  logic             not_full;
  logic             tag_match;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign last_idx  = IDX_W'(fill - CNT_W'(1));
  assign not_full  = fill < CNT_W'(ENTRIES);
  assign tag_match = tag_q == op_tag;

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_addr] <= tag_wdata;
    if (age_we) age_mem[wr_addr] <= age_wdata;
    if (pay_we) pay_mem[wr_addr] <= pay_wdata;
    tag_q <= tag_mem[rd_addr];
    age_q <= age_mem[rd_addr];
    pay_q <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(s_axis_tuser) == OP_CLEAR || fill == '0) begin
            state_next = S_DISPATCH;
          end else begin
            state_next = S_LOOK_RD;
          end
        end
      end
      S_LOOK_RD: state_next = S_LOOK_CMP;
      S_LOOK_CMP: begin
        if (tag_match || ptr == '0) begin
          state_next = S_DISPATCH;
        end else begin
          state_next = S_LOOK_RD;
        end
      end
      S_DISPATCH: begin
        case (op)
          OP_GET: state_next = found ? S_PAY_RD : S_OUT;
          OP_PUT: state_next = (found || not_full) ? S_WRITE : S_OLD_RD;
          OP_REMOVE: begin
            if (found && last_idx != idx) begin
              state_next = S_MOVE_RD;
            end else begin
              state_next = S_OUT;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_OLD_RD: state_next = S_OLD_CMP;
      S_OLD_CMP: begin
        if (ptr == IDX_W'(ENTRIES - 1)) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_OLD_RD;
        end
      end
      S_PAY_RD:    state_next = S_PAY_WAIT;
      S_PAY_WAIT:  state_next = S_OUT;
      S_MOVE_RD:   state_next = S_MOVE_WAIT;
      S_MOVE_WAIT: state_next = S_OUT;
      S_WRITE:     state_next = S_OUT;
      S_OUT: begin
        if (m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_addr   = ptr;
    wr_addr   = idx;
    tag_we    = 1'b0;
    age_we    = 1'b0;
    pay_we    = 1'b0;
    tag_wdata = op_tag;
    age_wdata = put_counter + AGE_W'(1);
    pay_wdata = op_data;
    case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_PAY_RD: rd_addr = idx;
      S_MOVE_RD: rd_addr = last_idx;
      S_MOVE_WAIT: begin
        // The last filled slot fills the hole left by the removed block.
        tag_we    = 1'b1;
        age_we    = 1'b1;
        pay_we    = 1'b1;
        tag_wdata = tag_q;
        age_wdata = age_q;
        pay_wdata = pay_q;
      end
      S_WRITE: begin
        tag_we = !found;
        age_we = 1'b1;
        pay_we = 1'b1;
      end
      S_OUT: m_axis_tvalid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      put_counter <= '0;
    end else begin
      case (state)
        S_DISPATCH: begin
          if (op == OP_CLEAR) begin
            fill <= '0;
          end else if (op == OP_REMOVE && found && last_idx == idx) begin
            fill <= fill - CNT_W'(1);
          end
        end
        S_MOVE_WAIT: fill <= fill - CNT_W'(1);
        S_WRITE: begin
          put_counter <= put_counter + AGE_W'(1);
          if (!found && not_full) fill <= fill + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op      <= op_t'(s_axis_tuser);
          op_tag  <= s_axis_tdata[31:0];
          op_data <= s_axis_tdata[32 +: DATA_WIDTH];
          found   <= 1'b0;
          ptr     <= last_idx;
        end
      end
      S_LOOK_CMP: begin
        if (tag_match) begin
          found <= 1'b1;
          idx   <= ptr;
        end else begin
          ptr <= ptr - IDX_W'(1);
        end
      end
      S_DISPATCH: begin
        res_hit  <= found;
        res_data <= '0;
        res_slot <= found ? SLOT_W'(idx) : '0;
        ptr      <= '0;
        if (op == OP_PUT && !found && not_full) idx <= IDX_W'(fill);
      end
      S_OLD_CMP: begin
        // Strict less-than keeps the lowest index on equal ages.
        if (ptr == '0 || age_q < best_age) begin
          best_age <= age_q;
          idx      <= ptr;
        end
        ptr <= ptr + IDX_W'(1);
      end
      S_PAY_WAIT: res_data <= pay_q;
      S_WRITE:    res_slot <= SLOT_W'(idx);
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {2'b00, res_slot, WORD_W'(res_data)};
  assign m_axis_tuser = res_hit;

endmodule
`default_nettype wire

FILE: design/asc_lru_checker.sv
// Port-level checker for the associative sector cache, bound to the top level.
`default_nettype none
module asc_lru_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [95:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // The block is never ready for a request while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready for a request while a result is pending");

  // An accepted request keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready again right after a request");

  // A miss never reports data; a put miss still reports the slot it filled.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[71:70] == 2'd0)
    else $error("miss result carries data");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind assoc_sector_cache_lru asc_lru_checker u_asc_lru_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: dv/asc_lru_result_checker.sv
// Watches both streams of the sector cache, predicts each result and compares it.
module asc_lru_result_checker
  import asc_lru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // block_id[31:0], data_in[95:32]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // data_out[63:0], slot[69:64], zero pad
  input  logic [0:0]  m_axis_tuser,   // hit[0]
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] data;
    logic [SLOT_W-1:0] slot;
  } cache_reply_t;

  logic [TAG_W-1:0]  slot_tag  [ENTRIES];
  logic [AGE_W-1:0]  slot_age  [ENTRIES];
  logic [WORD_W-1:0] slot_word [ENTRIES];
  int                used_slots;
  logic [AGE_W-1:0]  put_stamp;
  cache_reply_t      awaited_replies[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Applies one request to the shadow cache and returns the reply it should produce.
  function automatic cache_reply_t access_cache(op_t op, logic [TAG_W-1:0] tag,
                                                logic [WORD_W-1:0] word);
    cache_reply_t      r;
    int                idx;
    int                last;
    bit                found;
    logic [WORD_W-1:0] keep;
    r     = '0;
    idx   = 0;
    found = 1'b0;
    keep  = {WORD_W{1'b1}} >> (WORD_W - DATA_WIDTH);
    if (op == OP_CLEAR) begin
      used_slots = 0;
      foreach (slot_age[i]) slot_age[i] = '0;
    end else begin
      // Newest filled slot is searched first.
      for (int i = used_slots - 1; i >= 0 && !found; i--) begin
        if (slot_tag[i] == tag) begin
          found = 1'b1;
          idx   = i;
        end
      end
      case (op)
        OP_GET: begin
          if (found) begin
            r.data = slot_word[idx] & keep;
            r.slot = SLOT_W'(idx);
          end
        end
        OP_PUT: begin
          if (!found) begin
            if (used_slots >= ENTRIES) begin
              // Smallest age goes; a strict compare keeps the lowest index on ties.
              idx = 0;
              for (int i = 1; i < ENTRIES; i++) begin
                if (slot_age[i] < slot_age[idx]) idx = i;
              end
            end else begin
              idx = used_slots;
              used_slots++;
            end
            slot_tag[idx] = tag;
          end
          put_stamp      = put_stamp + 1'b1;
          slot_age[idx]  = put_stamp;
          slot_word[idx] = word & keep;
          r.slot         = SLOT_W'(idx);
        end
        default: begin
          if (found) begin
            // The last filled slot moves into the hole left by the removed block.
            last = used_slots - 1;
            if (last != idx) begin
              slot_tag[idx]  = slot_tag[last];
              slot_age[idx]  = slot_age[last];
              slot_word[idx] = slot_word[last];
            end
            used_slots--;
            r.slot = SLOT_W'(idx);
          end
        end
      endcase
    end
    r.hit = found;
    return r;
  endfunction

  always @(posedge clk) begin
    cache_reply_t want;
    if (rst) begin
      foreach (slot_tag[i]) begin
        slot_tag[i]  = '0;
        slot_age[i]  = '0;
        slot_word[i] = '0;
      end
      used_slots = 0;
      put_stamp  = '0;
      awaited_replies.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_replies.push_back(access_cache(op_t'(s_axis_tuser), s_axis_tdata[31:0],
                                               s_axis_tdata[95:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_replies.size() == 0) begin
          $error("result arrived with no request awaiting it");
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (m_axis_tuser[0] !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tdata[WORD_W-1:0] !== want.data) begin
            $error("data_out: expected %h, got %h", want.data, m_axis_tdata[WORD_W-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[WORD_W+SLOT_W-1:WORD_W] !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot,
                   m_axis_tdata[WORD_W+SLOT_W-1:WORD_W]);
            mismatches++;
          end
        end
      end
    end
    outstanding <= awaited_replies.size();
  end

endmodule

FILE: dv/assoc_sector_cache_lru_tb.sv
// Top of the sector cache testbench: clock, reset, request stimulus and verdict.
module assoc_sector_cache_lru_tb;
  import asc_lru_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 96;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // block_id[31:0], data_in[95:32]
  logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // data_out[63:0], slot[69:64], zero pad
  logic [0:0]  m_axis_tuser;        // hit[0]

  int mismatches;
  int outstanding;
  bit tx_gaps     = 1'b1;
  bit rx_gaps     = 1'b1;
  bit hold_armed  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assoc_sector_cache_lru DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  asc_lru_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Result side: random stalls, plus one long hold-off once the top arms it.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !(rx_gaps && $urandom_range(99) < 7);
      end
    end
  end

  task automatic send_req(input op_t op, input logic [31:0] tag, input logic [63:0] word);
    while (tx_gaps && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {word, tag};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_all_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly puts over a tag pool larger than the cache, so it fills and then evicts.
  task automatic run_round(input int items);
    logic [31:0] pool_base;
    logic [31:0] tag;
    logic [63:0] word;
    int          pick;
    op_t         op;
    pool_base = $urandom;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(199);
      if (pick < 150)      op = OP_PUT;
      else if (pick < 180) op = OP_GET;
      else if (pick < 196) op = OP_REMOVE;
      else if (pick < 197) op = OP_CLEAR;
      else                 op = op_t'($urandom_range(3));
      if ($urandom_range(99) < 5) tag = $urandom;
      else tag = pool_base + 32'($urandom_range(POOL_SIZE - 1)) * 32'h9E37_79B1;
      word = {$urandom, $urandom};
      send_req(op, tag, word);
    end
    send_req(OP_CLEAR, $urandom, {$urandom, $urandom});
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on an empty cache, extreme tags and words, hits, both remove shapes.
    send_req(OP_GET,    32'h0000_0000, 64'h0);
    send_req(OP_REMOVE, 32'h0000_0005, 64'h0);
    send_req(OP_CLEAR,  32'hFFFF_FFFF, {64{1'b1}});
    send_req(OP_PUT,    32'h0000_0000, 64'h0);
    send_req(OP_PUT,    32'hFFFF_FFFF, {64{1'b1}});
    send_req(OP_GET,    32'hFFFF_FFFF, 64'h0);
    send_req(OP_GET,    32'h0000_0000, {64{1'b1}});
    send_req(OP_PUT,    32'h0000_0000, 64'h5555_5555_5555_5555);
    send_req(OP_PUT,    32'h1234_5678, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(OP_PUT,    32'h0BAD_F00D, 64'h0123_4567_89AB_CDEF);
    send_req(OP_GET,    32'h0000_0000, 64'h0);
    send_req(OP_REMOVE, 32'h0000_0000, 64'h0);
    send_req(OP_GET,    32'h0BAD_F00D, 64'h0);
    send_req(OP_REMOVE, 32'h1234_5678, 64'h0);
    send_req(OP_REMOVE, 32'h1234_5678, 64'h0);
    send_req(OP_GET,    32'h1234_5678, 64'h0);
    send_req(OP_CLEAR,  32'h0BAD_F00D, 64'h0);
    send_req(OP_GET,    32'hFFFF_FFFF, 64'h0);

    run_round(205);
    // The sender keeps offering requests while the result side holds off.
    hold_armed = 1'b1;
    run_round(205);
    wait_all_replies();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_round(205);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_round(205);

    wait_all_replies();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("assoc_sector_cache_lru_tb OK");
    end else begin
      $display("assoc_sector_cache_lru_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("assoc_sector_cache_lru_tb NOT OK");
    $finish;
  end

endmodule

FILE: assoc_sector_cache_lru.f
design/asc_lru_pkg.sv
design/assoc_sector_cache_lru.sv
design/asc_lru_checker.sv
dv/asc_lru_result_checker.sv
dv/assoc_sector_cache_lru_tb.sv
